[design/vr_pkg.sv]
// ----------------------------------------------------------------------------
// vr_pkg
// shared types, constants and saturation helper for the refraction pipeline
// ----------------------------------------------------------------------------
package vr_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int DW            = 32;
    localparam int RAD_W         = 64;
    localparam int ROOT_W        = 32;
    localparam int WIDE_W        = 72;

    // side data carried alongside the square root
    typedef struct packed {
        logic [2:0][DW-1:0] nrm;
        logic [2:0][DW-1:0] perp;
    } vr_side_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7fffffff);
        lo = -WIDE_W'(64'sh80000000);
        if (v > hi) begin
            return DW'(32'h7fffffff);
        end else if (v < lo) begin
            return DW'(32'h80000000);
        end
        return v[DW-1:0];
    endfunction

endpackage

[design/vector_refraction.sv]
// ----------------------------------------------------------------------------
// vector_refraction
// refracts an incident direction at a surface by the vector form of snell's law
// ----------------------------------------------------------------------------
// Fully pipelined: one ray beat is accepted every cycle unless the output is
// stalled, and passes seven arithmetic stages, 32 square root stages of one root
// bit each, one product stage and the output register. The whole pipeline
// moves as one; when the output beat is held by m_tready low, s_tready drops
// in the same cycle. Total internal reflection is folded into |1 - |perp|^2|
// and raises no flag. All values are Q3.FRAC_BITS with floor rounding.
module vector_refraction import vr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // ray_x, ray_y, ray_z, normal_x, normal_y, normal_z, index_ratio
    input  logic [223:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_x, out_y, out_z
    output logic [95:0]   m_tdata
);

    localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) <<< FRAC_BITS;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic signed [DW-1:0] in_u [3];
    logic signed [DW-1:0] in_n [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_u[i] = s_tdata[i*DW +: DW];
            in_n[i] = s_tdata[(i+3)*DW +: DW];
        end
    end

    // stage a: dot products
    logic                 va_reg;
    logic signed [63:0]   pa_reg [3];
    logic signed [DW-1:0] ua_reg [3];
    logic signed [DW-1:0] na_reg [3];
    logic [DW-1:0]        eta_a_reg;
    // stage b: cosine
    logic                 vb_reg;
    logic signed [DW-1:0] cos_reg;
    logic signed [DW-1:0] ub_reg [3];
    logic signed [DW-1:0] nb_reg [3];
    logic [DW-1:0]        eta_b_reg;
    // stage c: cos * normal
    logic                 vc_reg;
    logic signed [DW-1:0] tc_reg [3];
    logic signed [DW-1:0] uc_reg [3];
    logic signed [DW-1:0] nc_reg [3];
    logic [DW-1:0]        eta_c_reg;
    // stage d: ray + cos * normal
    logic                 vd_reg;
    logic signed [DW-1:0] sd_reg [3];
    logic signed [DW-1:0] nd_reg [3];
    logic [DW-1:0]        eta_d_reg;
    // stage e: perp
    logic                 ve_reg;
    logic signed [DW-1:0] pe_reg [3];
    logic signed [DW-1:0] ne_reg [3];
    // stage f: squares
    logic                 vf_reg;
    logic signed [63:0]   qf_reg [3];
    logic signed [DW-1:0] pf_reg [3];
    logic signed [DW-1:0] nf_reg [3];
    // stage g: radicand
    logic                 vg_reg;
    logic [RAD_W-1:0]     rad_reg;
    vr_side_t             side_g_reg;
    // stage h: normal * sqrt
    logic                 vh_reg;
    logic signed [63:0]   mh_reg [3];
    logic signed [DW-1:0] ph_reg [3];
    // output
    logic                 vo_reg;
    logic [95:0]          out_reg;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    vr_side_t             sq_side;

    logic signed [63:0]       pa_next [3];
    logic signed [DW-1:0]     cos_next;
    logic signed [DW-1:0]     tc_next [3];
    logic signed [DW-1:0]     sd_next [3];
    logic signed [DW-1:0]     pe_next [3];
    logic signed [63:0]       qf_next [3];
    logic [RAD_W-1:0]         rad_next;
    vr_side_t                 side_next;
    logic signed [DW-1:0]     s_clip;
    logic signed [63:0]       mh_next [3];
    logic [95:0]              out_next;

    always_comb begin
        logic signed [WIDE_W-1:0] dot;
        logic signed [WIDE_W-1:0] cw;
        logic signed [WIDE_W-1:0] lensq;
        logic signed [WIDE_W-1:0] kv;
        logic signed [WIDE_W-1:0] kshift;
        logic signed [64:0]       pr65;
        logic signed [63:0]       pr;
        dot   = '0;
        lensq = '0;
        for (int i = 0; i < 3; i++) begin
            pa_next[i] = (64'(in_u[i]) * 64'(in_n[i])) >>> FRAC_BITS;
        end
        for (int i = 0; i < 3; i++) begin
            dot = dot + WIDE_W'(pa_reg[i]);
        end
        cw = -dot;
        if (cw > ONE) begin
            cw = ONE;
        end
        cos_next = sat32(cw);
        for (int i = 0; i < 3; i++) begin
            pr         = (64'(nb_reg[i]) * 64'(cos_reg)) >>> FRAC_BITS;
            tc_next[i] = sat32(WIDE_W'(pr));
            sd_next[i] = sat32(WIDE_W'(uc_reg[i]) + WIDE_W'(tc_reg[i]));
            pr65       = (65'(sd_reg[i]) * $signed({33'd0, eta_d_reg})) >>> FRAC_BITS;
            pe_next[i] = sat32(WIDE_W'(pr65));
            qf_next[i] = (64'(pe_reg[i]) * 64'(pe_reg[i])) >>> FRAC_BITS;
        end
        for (int i = 0; i < 3; i++) begin
            lensq = lensq + WIDE_W'(qf_reg[i]);
        end
        kv = ONE - lensq;
        if (kv < 0) begin
            kv = -kv;
        end
        kshift   = kv <<< FRAC_BITS;
        rad_next = kshift[RAD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            side_next.nrm[i]  = nf_reg[i];
            side_next.perp[i] = pf_reg[i];
        end
        s_clip = sq_root[ROOT_W-1] ? DW'(32'h7fffffff) : $signed(sq_root);
        for (int i = 0; i < 3; i++) begin
            mh_next[i] = (64'($signed(sq_side.nrm[i])) * 64'(s_clip)) >>> FRAC_BITS;
        end
        for (int i = 0; i < 3; i++) begin
            out_next[i*DW +: DW] = sat32(WIDE_W'(ph_reg[i]) - WIDE_W'(mh_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= sq_valid;
            vo_reg <= vh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= pa_next[i];
                ua_reg[i] <= in_u[i];
                na_reg[i] <= in_n[i];
                ub_reg[i] <= ua_reg[i];
                nb_reg[i] <= na_reg[i];
                tc_reg[i] <= tc_next[i];
                uc_reg[i] <= ub_reg[i];
                nc_reg[i] <= nb_reg[i];
                sd_reg[i] <= sd_next[i];
                nd_reg[i] <= nc_reg[i];
                pe_reg[i] <= pe_next[i];
                ne_reg[i] <= nd_reg[i];
                qf_reg[i] <= qf_next[i];
                pf_reg[i] <= pe_reg[i];
                nf_reg[i] <= ne_reg[i];
                mh_reg[i] <= mh_next[i];
                ph_reg[i] <= $signed(sq_side.perp[i]);
            end
            eta_a_reg  <= s_tdata[6*DW +: DW];
            eta_b_reg  <= eta_a_reg;
            eta_c_reg  <= eta_b_reg;
            eta_d_reg  <= eta_c_reg;
            cos_reg    <= cos_next;
            rad_reg    <= rad_next;
            side_g_reg <= side_next;
            out_reg    <= out_next;
        end
    end

    vr_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vg_reg),
        .radicand  (rad_reg),
        .in_side   (side_g_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && vh_reg) |=> m_tvalid)
        else $error("beat lost at output register");

endmodule

[design/vr_isqrt.sv]
// ----------------------------------------------------------------------------
// vr_isqrt
// pipelined floor integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module vr_isqrt import vr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    radicand,
    input  vr_side_t            in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output vr_side_t            out_side
);

    logic [RAD_W+1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];
    vr_side_t          side_reg  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - j;
        logic [RAD_W+1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic              valid_prev;
        vr_side_t          side_prev;
        logic [RAD_W+1:0]  trial;
        logic [RAD_W+1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign rem_prev   = {2'b00, radicand};
            assign root_prev  = '0;
            assign valid_prev = in_valid;
            assign side_prev  = in_side;
        end else begin : g_rest
            assign rem_prev   = rem_reg[j-1];
            assign root_prev  = root_reg[j-1];
            assign valid_prev = valid_reg[j-1];
            assign side_prev  = side_reg[j-1];
        end

        // (r + b)^2 - r^2 = 2*r*b + b^2
        always_comb begin
            trial = ({(RAD_W+2-ROOT_W)'(0), root_prev} << (BIT + 1))
                  + ((RAD_W+2)'(1) << (2 * BIT));
            if (rem_prev >= trial) begin
                rem_next  = rem_prev - trial;
                root_next = root_prev | (ROOT_W'(1) << BIT);
            end else begin
                rem_next  = rem_prev;
                root_next = root_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule
